// ----- hw/rtl/fsg_pkg.sv -----
// ============================================================================
// fsg_pkg
// Shared constants and types for the falling-sand grid block: operation
// codes, cell codes, field widths and the scan engine status bundle.
// ============================================================================
package fsg_pkg;

  localparam int FSG_ROWS_DEF = 32;
  localparam int FSG_COLS_DEF = 64;

  localparam int OP_W   = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;
  localparam int CODE_W = 8;

  localparam logic [OP_W-1:0] OP_PLACE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_SAND  = 8'h23;
  localparam logic [CODE_W-1:0] CODE_WATER = 8'h7E;
  localparam logic [CODE_W-1:0] CODE_AIR   = 8'h20;

  typedef struct packed {
    logic busy;
    logic done;
  } fsg_scan_stat_t;

endpackage

// ----- hw/rtl/fsg_ram.sv -----
// ============================================================================
// fsg_ram
// Simple dual-port synchronous memory: one write port and one read port
// with a registered read data output.
// ============================================================================
module fsg_ram
  import fsg_pkg::*;
#(
  parameter int DEPTH = FSG_ROWS_DEF * FSG_COLS_DEF,
  parameter int AW    = $clog2(FSG_ROWS_DEF * FSG_COLS_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CODE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/fsg_scan.sv -----
// ============================================================================
// fsg_scan
// Physics frame sequencer. Walks the old grid cell by cell, probes the
// neighbors of each sand or water cell in priority order, and swaps the
// two entries of the work copy when a move is allowed.
// ============================================================================
module fsg_scan
  import fsg_pkg::*;
#(
  parameter int ROWS = FSG_ROWS_DEF,
  parameter int COLS = FSG_COLS_DEF,
  parameter int AW   = $clog2(FSG_ROWS_DEF * FSG_COLS_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CODE_W-1:0] grid_rdata,
  output logic [AW-1:0]     grid_raddr,
  input  logic [CODE_W-1:0] work_rdata,
  output logic [AW-1:0]     work_raddr,
  output logic              work_we,
  output logic [AW-1:0]     work_waddr,
  output logic [CODE_W-1:0] work_wdata,
  output fsg_scan_stat_t    stat
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  localparam logic [2:0] SC_IDLE     = 3'd0;
  localparam logic [2:0] SC_RD_HERE  = 3'd1;
  localparam logic [2:0] SC_CHK_HERE = 3'd2;
  localparam logic [2:0] SC_CHK_CAND = 3'd3;
  localparam logic [2:0] SC_WK_HERE  = 3'd4;
  localparam logic [2:0] SC_WK_TGT   = 3'd5;
  localparam logic [2:0] SC_WK_WR    = 3'd6;

  logic [2:0]        st_r, st_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [4:0]        mask_r, mask_nxt;
  logic              sand_r, sand_nxt;
  logic [AW-1:0]     tgt_r, tgt_nxt;
  logic [CODE_W-1:0] wh_r, wh_nxt;
  logic              done_r, done_nxt;

  logic       is_sand, is_water, enter;
  logic       last_row, first_col, last_col;
  logic [4:0] mask_new, mask_rest;
  logic       adv;

  function automatic logic [AW-1:0] cand_addr(input logic [AW-1:0] base,
                                               input logic [4:0] m);
    logic [AW-1:0] a;
    a = base;
    if (m[0]) begin
      a = base + AW'(COLS);
    end else if (m[1]) begin
      a = base + AW'(COLS - 1);
    end else if (m[2]) begin
      a = base + AW'(COLS + 1);
    end else if (m[3]) begin
      a = base - AW'(1);
    end else if (m[4]) begin
      a = base + AW'(1);
    end
    return a;
  endfunction

  assign is_sand   = (grid_rdata == CODE_SAND);
  assign is_water  = (grid_rdata == CODE_WATER);
  assign enter     = (grid_rdata == CODE_AIR) || (sand_r && grid_rdata == CODE_WATER);
  assign last_row  = (row_r == RW'(ROWS - 1));
  assign first_col = (col_r == '0);
  assign last_col  = (col_r == CW'(COLS - 1));

  // Candidate order: below, below-left, below-right, left, right.
  assign mask_new  = {is_water && !last_col, is_water && !first_col,
                      !last_row && !last_col, !last_row && !first_col, !last_row};
  assign mask_rest = mask_r & (mask_r - 5'd1);

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    mask_nxt   = mask_r;
    sand_nxt   = sand_r;
    tgt_nxt    = tgt_r;
    wh_nxt     = wh_r;
    done_nxt   = 1'b0;
    grid_raddr = idx_r;
    work_raddr = idx_r;
    work_we    = 1'b0;
    work_waddr = idx_r;
    work_wdata = work_rdata;
    adv        = 1'b0;

    case (st_r)
      SC_IDLE: begin
        if (start) begin
          idx_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
          st_nxt  = SC_RD_HERE;
        end
      end
      SC_RD_HERE: begin
        st_nxt = SC_CHK_HERE;
      end
      SC_CHK_HERE: begin
        sand_nxt   = is_sand;
        mask_nxt   = mask_new;
        grid_raddr = cand_addr(idx_r, mask_new);
        if ((is_sand || is_water) && mask_new != '0) begin
          st_nxt = SC_CHK_CAND;
        end else begin
          adv = 1'b1;
        end
      end
      SC_CHK_CAND: begin
        if (enter) begin
          tgt_nxt = cand_addr(idx_r, mask_r);
          st_nxt  = SC_WK_HERE;
        end else if (mask_rest != '0) begin
          mask_nxt   = mask_rest;
          grid_raddr = cand_addr(idx_r, mask_rest);
        end else begin
          adv = 1'b1;
        end
      end
      SC_WK_HERE: begin
        wh_nxt     = work_rdata;
        work_raddr = tgt_r;
        st_nxt     = SC_WK_TGT;
      end
      SC_WK_TGT: begin
        work_we    = 1'b1;
        work_waddr = idx_r;
        work_wdata = work_rdata;
        st_nxt     = SC_WK_WR;
      end
      SC_WK_WR: begin
        work_we    = 1'b1;
        work_waddr = tgt_r;
        work_wdata = wh_r;
        adv        = 1'b1;
      end
      default: begin
        st_nxt = SC_IDLE;
      end
    endcase

    if (adv) begin
      if (last_row && last_col) begin
        st_nxt   = SC_IDLE;
        done_nxt = 1'b1;
      end else begin
        st_nxt  = SC_RD_HERE;
        idx_nxt = idx_r + AW'(1);
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SC_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    idx_r  <= idx_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    mask_r <= mask_nxt;
    sand_r <= sand_nxt;
    tgt_r  <= tgt_nxt;
    wh_r   <= wh_nxt;
  end

  assign stat.busy = (st_r != SC_IDLE);
  assign stat.done = done_r;

endmodule

// ----- hw/rtl/falling_sand_grid_step.sv -----
// ============================================================================
// falling_sand_grid_step
// Falling-sand grid: place and read cell codes, advance one physics frame.
// ============================================================================
// Usage: the in_ channel carries one beat per item. A place beat writes
// in_cell_code at (in_row, in_column) if that cell lies inside the grid.
// A read beat returns the cell code, or zero for a cell outside the grid,
// on the out_ channel, by way of the READ state and the output register.
// A tick beat runs one frame: the grid is copied into the work memory,
// each cell is scanned, and the work memory is copied back. Operation
// code 3 is dropped. After reset the grid memory is filled with air, one
// cell per cycle; in_ready stays low during that pass.
// A read result sits in an output register until taken. While it waits,
// place and tick beats are still accepted; a further read beat waits until
// the output register is free.
// ============================================================================
module falling_sand_grid_step
  import fsg_pkg::*;
#(
  parameter int ROWS = FSG_ROWS_DEF,
  parameter int COLS = FSG_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [COL_W-1:0]  in_column,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [CODE_W-1:0] in_cell_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_read_code
);

  localparam int N     = ROWS * COLS;
  localparam int AW    = $clog2(N);
  localparam int CNT_W = AW + 1;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_READ     = 3'd2;
  localparam logic [2:0] ST_COPY_IN  = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;
  localparam logic [2:0] ST_COPY_OUT = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cp_vld_r, cp_vld_nxt;
  logic [AW-1:0]     cp_addr_r, cp_addr_nxt;
  logic              inside_r, inside_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_data_r, out_data_nxt;
  logic              scan_start_r, scan_start_nxt;

  logic              in_inside, acc, cnt_busy;
  logic [AW-1:0]     in_addr;

  logic              grid_we;
  logic [AW-1:0]     grid_waddr, grid_raddr;
  logic [CODE_W-1:0] grid_wdata, grid_rdata;
  logic              work_we;
  logic [AW-1:0]     work_waddr, work_raddr;
  logic [CODE_W-1:0] work_wdata, work_rdata;

  logic [AW-1:0]     scan_graddr, scan_wraddr, scan_waddr;
  logic              scan_we;
  logic [CODE_W-1:0] scan_wdata;
  fsg_scan_stat_t    scan_stat;

  assign in_inside = (32'(in_row) < ROWS) && (32'(in_column) < COLS);
  assign in_addr   = AW'(AW'(in_row) * AW'(COLS)) + AW'(in_column);
  assign in_ready  = (state_r == ST_IDLE) &&
                     (!out_valid_r || out_ready || in_operation != OP_READ);
  assign acc       = in_valid && in_ready;
  assign cnt_busy  = (cnt_r < CNT_W'(N));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cp_vld_nxt     = 1'b0;
    cp_addr_nxt    = cnt_r[AW-1:0];
    inside_nxt     = inside_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    scan_start_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_operation)
            OP_READ: begin
              inside_nxt = in_inside;
              state_nxt  = ST_READ;
            end
            OP_TICK: begin
              cnt_nxt   = '0;
              state_nxt = ST_COPY_IN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = inside_r ? grid_rdata : '0;
        state_nxt     = ST_IDLE;
      end
      ST_COPY_IN: begin
        cp_vld_nxt = cnt_busy;
        if (cnt_busy) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          scan_start_nxt = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          cnt_nxt   = '0;
          state_nxt = ST_COPY_OUT;
        end
      end
      ST_COPY_OUT: begin
        cp_vld_nxt = cnt_busy;
        if (cnt_busy) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      cp_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      scan_start_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cp_vld_r     <= cp_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      scan_start_r <= scan_start_nxt;
    end
    cp_addr_r  <= cp_addr_nxt;
    inside_r   <= inside_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = in_addr;
    grid_wdata = in_cell_code;
    case (state_r)
      ST_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = cnt_r[AW-1:0];
        grid_wdata = CODE_AIR;
      end
      ST_IDLE: begin
        grid_we = acc && (in_operation == OP_PLACE) && in_inside;
      end
      ST_COPY_OUT: begin
        grid_we    = cp_vld_r;
        grid_waddr = cp_addr_r;
        grid_wdata = work_rdata;
      end
      default: begin
      end
    endcase

    case (state_r)
      ST_COPY_IN: grid_raddr = cnt_r[AW-1:0];
      ST_SCAN:    grid_raddr = scan_graddr;
      default:    grid_raddr = in_addr;
    endcase

    work_we    = scan_we;
    work_waddr = scan_waddr;
    work_wdata = scan_wdata;
    work_raddr = scan_wraddr;
    case (state_r)
      ST_COPY_IN: begin
        work_we    = cp_vld_r;
        work_waddr = cp_addr_r;
        work_wdata = grid_rdata;
      end
      ST_COPY_OUT: begin
        work_we    = 1'b0;
        work_raddr = cnt_r[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  fsg_ram #(
    .DEPTH (N),
    .AW    (AW)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  fsg_ram #(
    .DEPTH (N),
    .AW    (AW)
  ) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .raddr (work_raddr),
    .rdata (work_rdata)
  );

  fsg_scan #(
    .ROWS (ROWS),
    .COLS (COLS),
    .AW   (AW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start_r),
    .grid_rdata (grid_rdata),
    .grid_raddr (scan_graddr),
    .work_rdata (work_rdata),
    .work_raddr (scan_wraddr),
    .work_we    (scan_we),
    .work_waddr (scan_waddr),
    .work_wdata (scan_wdata),
    .stat       (scan_stat)
  );

  assign out_valid     = out_valid_r;
  assign out_read_code = out_data_r;

`ifndef SYNTHESIS
  a_scan_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_stat.busy || scan_stat.done) |-> (state_r == ST_SCAN))
    else $error("Scan engine active outside the scan phase.");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("Input accepted during the clearing pass.");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_READ) |-> ##2 out_valid)
    else $error("Read beat gave no result two cycles later.");

  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !grid_we)
    else $error("Grid memory written during the scan phase.");
`endif

endmodule

// ----- dv/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for falling_sand_grid_step. A directed table covers
// reset contents, field extremes, the dropped op code, grid edges and cells
// that never move. Random scenes of place, frame advance and read items
// follow. Each read beat is compared with a table entry or a behavioral grid.
// ============================================================================
module tb_top;
  import fsg_pkg::*;

  localparam int ROWS = FSG_ROWS_DEF;
  localparam int COLS = FSG_COLS_DEF;
  localparam logic [OP_W-1:0]   OP_SPARE  = 2'd3;
  localparam logic [CODE_W-1:0] CODE_ROCK = 8'h41;
  localparam int ITEM_TARGET = 90;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CODE_W-1:0] code;
    logic              has_want;
    logic [CODE_W-1:0] want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [25] = '{
    '{OP_READ,  6'd0,  5'd0,  8'h00,      1'b1, CODE_AIR},
    '{OP_READ,  6'd63, 5'd31, 8'h00,      1'b1, CODE_AIR},
    '{OP_PLACE, 6'd0,  5'd0,  8'hFF,      1'b0, 8'h00},
    '{OP_READ,  6'd0,  5'd0,  8'h00,      1'b1, 8'hFF},
    '{OP_PLACE, 6'd63, 5'd31, 8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd63, 5'd31, 8'hFF,      1'b1, 8'h00},
    '{OP_SPARE, 6'd63, 5'd31, 8'hFF,      1'b0, 8'h00},
    '{OP_READ,  6'd63, 5'd31, 8'h00,      1'b1, 8'h00},
    '{OP_PLACE, 6'd0,  5'd0,  CODE_SAND,  1'b0, 8'h00},
    '{OP_PLACE, 6'd5,  5'd31, CODE_SAND,  1'b0, 8'h00},
    '{OP_PLACE, 6'd0,  5'd31, CODE_WATER, 1'b0, 8'h00},
    '{OP_PLACE, 6'd63, 5'd30, CODE_SAND,  1'b0, 8'h00},
    '{OP_PLACE, 6'd10, 5'd31, CODE_WATER, 1'b0, 8'h00},
    '{OP_PLACE, 6'd10, 5'd30, CODE_SAND,  1'b0, 8'h00},
    '{OP_PLACE, 6'd20, 5'd31, CODE_ROCK,  1'b0, 8'h00},
    '{OP_PLACE, 6'd20, 5'd30, CODE_WATER, 1'b0, 8'h00},
    '{OP_TICK,  6'd0,  5'd0,  8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd0,  5'd1,  8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd0,  5'd0,  8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd5,  5'd31, 8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd1,  5'd31, 8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd62, 5'd31, 8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd10, 5'd31, 8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd9,  5'd31, 8'h00,      1'b0, 8'h00},
    '{OP_READ,  6'd19, 5'd31, 8'h00,      1'b0, 8'h00}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [COL_W-1:0]  in_column;
  logic [ROW_W-1:0]  in_row;
  logic [CODE_W-1:0] in_cell_code;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] out_read_code;

  logic [CODE_W-1:0] grid_now  [ROWS*COLS];
  logic [CODE_W-1:0] grid_next [ROWS*COLS];
  logic [CODE_W-1:0] expected_codes [$];
  logic [CODE_W-1:0] head_code;

  int  errors       = 0;
  int  items_sent   = 0;
  int  spare_sent   = 0;
  int  frames_sent  = 0;
  int  reads_seen   = 0;
  int  burst_left   = 0;
  int  frames_left  = 16;
  bit  hold_start   = 1'b0;
  bit  pressure_done = 1'b0;

  falling_sand_grid_step uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_column    (in_column),
    .in_row       (in_row),
    .in_cell_code (in_cell_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_code(out_read_code)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit can_enter(int r, int c, bit is_sand);
    logic [CODE_W-1:0] v;
    if (r >= ROWS || c < 0 || c >= COLS) return 1'b0;
    v = grid_now[r*COLS + c];
    return (v == CODE_AIR) || (is_sand && v == CODE_WATER);
  endfunction

  function automatic void swap_next(int a, int b);
    logic [CODE_W-1:0] t;
    t = grid_next[a];
    grid_next[a] = grid_next[b];
    grid_next[b] = t;
  endfunction

  function automatic void advance_frame();
    int idx;
    bit is_sand;
    logic [CODE_W-1:0] v;
    grid_next = grid_now;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        idx = r*COLS + c;
        v = grid_now[idx];
        is_sand = (v == CODE_SAND);
        if (!is_sand && v != CODE_WATER) continue;
        if (can_enter(r + 1, c, is_sand)) swap_next(idx, idx + COLS);
        else if (can_enter(r + 1, c - 1, is_sand)) swap_next(idx, idx + COLS - 1);
        else if (can_enter(r + 1, c + 1, is_sand)) swap_next(idx, idx + COLS + 1);
        else if (!is_sand && can_enter(r, c - 1, 1'b0)) swap_next(idx, idx - 1);
        else if (!is_sand && can_enter(r, c + 1, 1'b0)) swap_next(idx, idx + 1);
      end
    end
    grid_now = grid_next;
  endfunction

  function automatic void apply_to_grid(logic [OP_W-1:0] op, logic [COL_W-1:0] col,
                                        logic [ROW_W-1:0] row, logic [CODE_W-1:0] code);
    bit in_grid;
    in_grid = (row < ROWS) && (col < COLS);
    case (op)
      OP_PLACE: begin
        if (in_grid) grid_now[row*COLS + col] = code;
      end
      OP_TICK: begin
        advance_frame();
      end
      OP_READ: begin
        expected_codes.push_back(in_grid ? grid_now[row*COLS + col] : '0);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) return CODE_SAND;
    if (sel < 14) return CODE_WATER;
    if (sel < 17) return CODE_AIR;
    return CODE_W'($urandom_range(0, 255));
  endfunction

  task automatic put_beat(input logic [OP_W-1:0] op, input logic [COL_W-1:0] col,
                          input logic [ROW_W-1:0] row, input logic [CODE_W-1:0] code,
                          input bit has_want, input logic [CODE_W-1:0] want);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_column    <= col;
    in_row       <= row;
    in_cell_code <= code;
    do @(posedge clk); while (!in_ready);
    if (op == OP_SPARE) spare_sent++;
    else items_sent++;
    if (op == OP_TICK) frames_sent++;
    if (op == OP_READ && has_want) expected_codes.push_back(want);
    else apply_to_grid(op, col, row, code);
  endtask

  task automatic run_scene(input bit allow_frames);
    int base_r;
    int base_c;
    int rd_r;
    int sel;
    sel = $urandom_range(0, 3);
    base_r = (sel == 0) ? 0 : (sel == 1) ? ROWS - 4 : $urandom_range(0, ROWS - 4);
    sel = $urandom_range(0, 3);
    base_c = (sel == 0) ? 0 : (sel == 1) ? COLS - 4 : $urandom_range(0, COLS - 4);
    repeat ($urandom_range(3, 8))
      put_beat(OP_PLACE, COL_W'(base_c + $urandom_range(0, 3)),
               ROW_W'(base_r + $urandom_range(0, 3)), pick_code(), 1'b0, '0);
    if (allow_frames && frames_left > 0) begin
      put_beat(OP_TICK, COL_W'($urandom), ROW_W'($urandom), CODE_W'($urandom),
               1'b0, '0);
      frames_left--;
      if (frames_left > 0 && $urandom_range(0, 2) == 0) begin
        put_beat(OP_TICK, COL_W'($urandom), ROW_W'($urandom), CODE_W'($urandom),
                 1'b0, '0);
        frames_left--;
      end
    end
    repeat ($urandom_range(2, 6)) begin
      rd_r = base_r + $urandom_range(0, 5);
      if (rd_r > ROWS - 1) rd_r = ROWS - 1;
      put_beat(OP_READ, COL_W'(base_c + $urandom_range(0, 3)), ROW_W'(rd_r),
               CODE_W'($urandom), 1'b0, '0);
    end
  endtask

  initial begin
    int mode;
    int span;
    int phase;
    int hold_left;
    mode = 0;
    span = 0;
    phase = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = 80;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 120);
      end
      span--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= (phase % 5) < 3;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reads_seen++;
      if (expected_codes.size() == 0) begin
        $error("read_code: no beat expected, actual %02h", out_read_code);
        errors++;
      end else begin
        head_code = expected_codes.pop_front();
        if (out_read_code !== head_code) begin
          $error("read_code: expected %02h, actual %02h", head_code, out_read_code);
          errors++;
        end
      end
    end
  end

  initial begin
    #24_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_column    = '0;
    in_row       = '0;
    in_cell_code = '0;
    foreach (grid_now[i]) grid_now[i] = CODE_AIR;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      put_beat(DIRECTED[i].op, DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].code,
               DIRECTED[i].has_want, DIRECTED[i].want);

    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent > 70) begin
        // The result register fills while the receiver is held off, so
        // the second read beat must back up the input channel.
        pressure_done = 1'b1;
        hold_start = 1'b1;
        repeat (6)
          put_beat(OP_READ, COL_W'($urandom), ROW_W'($urandom), CODE_W'($urandom),
                   1'b0, '0);
        put_beat(OP_PLACE, COL_W'($urandom), ROW_W'($urandom), pick_code(), 1'b0, '0);
      end else begin
        case ($urandom_range(0, 9))
          7: put_beat(OP_SPARE, COL_W'($urandom), ROW_W'($urandom),
                      CODE_W'($urandom), 1'b0, '0);
          8: put_beat(OP_PLACE, COL_W'($urandom), ROW_W'($urandom),
                      CODE_W'($urandom), 1'b0, '0);
          9: put_beat(OP_READ, COL_W'($urandom), ROW_W'($urandom),
                      CODE_W'($urandom), 1'b0, '0);
          default: run_scene($urandom_range(0, 4) != 0);
        endcase
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Run covered %0d accepted items, %0d of them frame advances, plus %0d spare op codes.",
             items_sent, frames_sent, spare_sent);
    $display("Checked %0d read beats against the behavioral grid.", reads_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/fsg_pkg.sv
hw/rtl/fsg_ram.sv
hw/rtl/fsg_scan.sv
hw/rtl/falling_sand_grid_step.sv
dv/tb_top.sv
